// ----- rtl/core/hhmm_pkg.sv -----
// shared types, constants and address decode for the handheld memory map
package hhmm_pkg;

    localparam int RAM_BANKS       = 8;
    localparam int DMA_LENGTH      = 160;
    localparam int CYCLES_PER_BYTE = 4;
    localparam int MAX_RESULTS     = 64;

    localparam int BANK_SIZE   = 4096;
    localparam int BANK_W      = $clog2(RAM_BANKS);
    localparam int WRAM_DEPTH  = RAM_BANKS * BANK_SIZE;
    localparam int WRAM_AW     = $clog2(WRAM_DEPTH);
    localparam int HRAM_DEPTH  = 127;
    localparam int HRAM_AW     = 7;
    localparam int ACCUM_W     = 9;
    localparam int ACCUM_MAX   = 511;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DMA   = 2'd2;

    // target codes
    localparam logic [4:0] TGT_ROM      = 5'd0;
    localparam logic [4:0] TGT_VRAM     = 5'd1;
    localparam logic [4:0] TGT_CART_RAM = 5'd2;
    localparam logic [4:0] TGT_WRAM     = 5'd3;
    localparam logic [4:0] TGT_OAM      = 5'd4;
    localparam logic [4:0] TGT_UNUSABLE = 5'd5;
    localparam logic [4:0] TGT_JOYPAD   = 5'd6;
    localparam logic [4:0] TGT_SERIAL   = 5'd7;
    localparam logic [4:0] TGT_TIMER    = 5'd8;
    localparam logic [4:0] TGT_INT_FLAG = 5'd9;
    localparam logic [4:0] TGT_AUDIO    = 5'd10;
    localparam logic [4:0] TGT_WAVE     = 5'd11;
    localparam logic [4:0] TGT_VIDEO    = 5'd12;
    localparam logic [4:0] TGT_OWN      = 5'd13;
    localparam logic [4:0] TGT_HRAM     = 5'd14;
    localparam logic [4:0] TGT_INT_EN   = 5'd15;
    localparam logic [4:0] TGT_UNMAPPED = 5'd16;

    // own register addresses
    localparam logic [15:0] ADDR_DMA   = 16'hFF46;
    localparam logic [15:0] ADDR_SPEED = 16'hFF4D;
    localparam logic [15:0] ADDR_BANK  = 16'hFF70;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  cycles;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  target;
        logic [15:0] target_address;
        logic [7:0]  data;
        logic        data_valid;
        logic [7:0]  oam_offset;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [4:0]  target;
        logic [15:0] addr;
    } t_dec;

    function automatic logic [4:0] f_io_target(input logic [15:0] a);
        logic [4:0] t;
        priority if (a == 16'hFF00) t = TGT_JOYPAD;
        else if (a == 16'hFF01 || a == 16'hFF02) t = TGT_SERIAL;
        else if (a >= 16'hFF04 && a <= 16'hFF07) t = TGT_TIMER;
        else if (a == 16'hFF0F) t = TGT_INT_FLAG;
        else if (a >= 16'hFF30 && a <= 16'hFF3F) t = TGT_WAVE;
        else if (a >= 16'hFF10 && a <= 16'hFF2F) t = TGT_AUDIO;
        else if (a == ADDR_DMA || a == ADDR_SPEED || a == ADDR_BANK) t = TGT_OWN;
        else if ((a >= 16'hFF40 && a <= 16'hFF4B) || a == 16'hFF4F) t = TGT_VIDEO;
        else t = TGT_UNMAPPED;
        return t;
    endfunction

    function automatic t_dec f_decode(input logic [15:0] a_in);
        t_dec d;
        logic [15:0] a;
        a = a_in;
        // echo region folds onto work ram
        if (a >= 16'hE000 && a <= 16'hFDFF) a = a - 16'h2000;
        d.addr = a;
        priority if (a <= 16'h7FFF) d.target = TGT_ROM;
        else if (a <= 16'h9FFF) d.target = TGT_VRAM;
        else if (a <= 16'hBFFF) d.target = TGT_CART_RAM;
        else if (a <= 16'hDFFF) d.target = TGT_WRAM;
        else if (a <= 16'hFE9F) d.target = TGT_OAM;
        else if (a <= 16'hFEFF) d.target = TGT_UNUSABLE;
        else if (a <= 16'hFF7F) d.target = f_io_target(a);
        else if (a <= 16'hFFFE) d.target = TGT_HRAM;
        else d.target = TGT_INT_EN;
        return d;
    endfunction

    // 0xC000..0xCFFF is fixed bank 0, 0xD000..0xDFFF the selected bank
    function automatic logic [WRAM_AW-1:0] f_wram_index(input logic [15:0] a,
                                                        input logic [2:0] bank);
        logic [2:0]        b;
        logic [BANK_W-1:0] sel;
        b   = 3'(bank % RAM_BANKS);
        sel = a[12] ? b[BANK_W-1:0] : '0;
        return {sel, a[11:0]};
    endfunction

endpackage

// ----- rtl/core/handheld_memory_map_with_oam_dma_unit.sv -----
// memory map decoder with banked work ram, high ram, own registers and oam dma
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+--------------------------------------
//  command  | start, busy, i_item      | beat taken when start high, busy low
//  result   | o_done, o_result         | one-cycle strobe, no back pressure
//
// a read passes decode, memory read and the result register to its result,
// a write decode and the result register; each dma byte of a tick passes an
// issue state and a read state. after reset busy stays high while a sweep
// zeroes the work ram and high ram, one entry per cycle.
// results cannot be stalled; a result is shown while the next command is taken.
module handheld_memory_map_with_oam_dma_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  hhmm_pkg::t_item         i_item,
    output logic                    o_done,
    output hhmm_pkg::t_result       o_result
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDATA  = 3'd3;
    localparam logic [2:0] ST_DMA    = 3'd4;
    localparam logic [2:0] ST_DMA_RD = 3'd5;

    localparam logic [hhmm_pkg::ACCUM_W-1:0] CPB_A =
        hhmm_pkg::ACCUM_W'(hhmm_pkg::CYCLES_PER_BYTE);
    localparam logic [hhmm_pkg::RES_CNT_W-1:0] MAX_N =
        hhmm_pkg::RES_CNT_W'(hhmm_pkg::MAX_RESULTS);

    logic [2:0]                          r_state;
    logic [hhmm_pkg::WRAM_AW-1:0]        r_clr_idx;
    hhmm_pkg::t_item                     r_item;
    hhmm_pkg::t_dec                      r_dec;
    logic [2:0]                          r_bank;
    logic [7:0]                          r_speed;
    logic                                r_dma_busy;
    logic [15:0]                         r_dma_base;
    logic [7:0]                          r_dma_count;
    logic [hhmm_pkg::ACCUM_W-1:0]        r_accum;
    logic [hhmm_pkg::RES_CNT_W-1:0]      r_n;
    logic                                r_done;
    hhmm_pkg::t_result                   r_out;

    logic [7:0] r_wram [hhmm_pkg::WRAM_DEPTH];
    logic [7:0] r_hram [hhmm_pkg::HRAM_DEPTH];
    logic [7:0] r_wram_q;
    logic [7:0] r_hram_q;

    logic [15:0]                   dma_src;
    hhmm_pkg::t_dec                dec;
    logic [hhmm_pkg::WRAM_AW-1:0]  wram_ra;
    logic [hhmm_pkg::HRAM_AW-1:0]  hram_ra;
    logic                          wram_we;
    logic [hhmm_pkg::WRAM_AW-1:0]  wram_wa;
    logic                          hram_we;
    logic [hhmm_pkg::HRAM_AW-1:0]  hram_wa;
    logic [7:0]                    mem_wd;
    logic                          is_write;
    logic                          own_write;
    logic [9:0]                    acc_sum;
    logic [7:0]                    rd_data;
    logic                          rd_valid;
    logic [8:0]                    cnt_next;
    logic                          dma_still;
    logic [hhmm_pkg::RES_CNT_W-1:0] n_plus;
    logic                          dma_more;

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    assign dma_src = r_dma_base + {8'd0, r_dma_count};
    assign dec     = hhmm_pkg::f_decode((r_state == ST_DMA) ? dma_src : r_item.address);
    assign wram_ra = hhmm_pkg::f_wram_index(dec.addr, r_bank);
    assign hram_ra = dec.addr[hhmm_pkg::HRAM_AW-1:0];

    assign is_write = (r_state == ST_EXEC) && (r_item.cmd == hhmm_pkg::CMD_WRITE);
    assign own_write = is_write && (dec.target == hhmm_pkg::TGT_OWN);

    // clear sweep and write commands share the write port
    always_comb begin
        if (r_state == ST_CLEAR) begin
            wram_we = 1'b1;
            wram_wa = r_clr_idx;
            hram_we = ({{(16 - hhmm_pkg::WRAM_AW){1'b0}}, r_clr_idx} <
                       16'(hhmm_pkg::HRAM_DEPTH));
            hram_wa = r_clr_idx[hhmm_pkg::HRAM_AW-1:0];
            mem_wd  = 8'h00;
        end else begin
            wram_we = is_write && (dec.target == hhmm_pkg::TGT_WRAM);
            wram_wa = wram_ra;
            hram_we = is_write && (dec.target == hhmm_pkg::TGT_HRAM);
            hram_wa = hram_ra;
            mem_wd  = r_item.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wram_we) begin
            r_wram[wram_wa] <= mem_wd;
        end
        r_wram_q <= r_wram[wram_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hram_we) begin
            r_hram[hram_wa] <= mem_wd;
        end
        r_hram_q <= r_hram[hram_ra];
    end

    // data the block itself supplies for a read or dma byte
    always_comb begin
        rd_data  = 8'h00;
        rd_valid = 1'b0;
        unique case (r_dec.target)
            hhmm_pkg::TGT_WRAM: begin
                rd_data  = r_wram_q;
                rd_valid = 1'b1;
            end
            hhmm_pkg::TGT_HRAM: begin
                rd_data  = r_hram_q;
                rd_valid = 1'b1;
            end
            hhmm_pkg::TGT_UNUSABLE, hhmm_pkg::TGT_UNMAPPED: begin
                rd_data  = 8'hFF;
                rd_valid = 1'b1;
            end
            hhmm_pkg::TGT_OWN: begin
                rd_valid = 1'b1;
                priority if (r_dec.addr == hhmm_pkg::ADDR_SPEED) rd_data = r_speed | 8'h7E;
                else if (r_dec.addr == hhmm_pkg::ADDR_BANK) rd_data = {5'b11111, r_bank};
                else rd_data = 8'hFF;
            end
            default: begin
                rd_data  = 8'h00;
                rd_valid = 1'b0;
            end
        endcase
    end

    assign acc_sum   = {1'b0, r_accum} + {2'b00, r_item.cycles};
    assign cnt_next  = {1'b0, r_dma_count} + 9'd1;
    assign dma_still = !(cnt_next >= 9'(hhmm_pkg::DMA_LENGTH));
    assign n_plus    = r_n + 1'b1;
    assign dma_more  = dma_still && (r_accum >= CPB_A) && (n_plus < MAX_N);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_bank      <= 3'd1;
            r_speed     <= 8'h00;
            r_dma_busy  <= 1'b0;
            r_dma_base  <= 16'h0000;
            r_dma_count <= 8'h00;
            r_accum     <= '0;
            r_n         <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == hhmm_pkg::WRAM_AW'(hhmm_pkg::WRAM_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_dec <= dec;
                    unique case (r_item.cmd)
                        hhmm_pkg::CMD_READ: begin
                            r_state <= ST_RDATA;
                        end
                        hhmm_pkg::CMD_WRITE: begin
                            r_out.kind           <= hhmm_pkg::KIND_WRITE;
                            r_out.target         <= dec.target;
                            r_out.target_address <= dec.addr;
                            r_out.data           <= r_item.write_data;
                            r_out.data_valid     <= (dec.target == hhmm_pkg::TGT_WRAM) ||
                                                    (dec.target == hhmm_pkg::TGT_HRAM) ||
                                                    (dec.target == hhmm_pkg::TGT_UNUSABLE) ||
                                                    (dec.target == hhmm_pkg::TGT_UNMAPPED) ||
                                                    (dec.target == hhmm_pkg::TGT_OWN);
                            r_out.oam_offset     <= 8'h00;
                            r_out.last           <= 1'b1;
                            r_done               <= 1'b1;
                            r_state              <= ST_IDLE;
                            if (own_write) begin
                                priority if (dec.addr == hhmm_pkg::ADDR_DMA) begin
                                    r_dma_busy  <= 1'b1;
                                    r_dma_base  <= {r_item.write_data, 8'h00};
                                    r_dma_count <= 8'h00;
                                    r_accum     <= '0;
                                end else if (dec.addr == hhmm_pkg::ADDR_SPEED) begin
                                    r_speed <= (r_speed & 8'h80) |
                                               (r_item.write_data & 8'h01) | 8'h7E;
                                end else begin
                                    r_bank <= (r_item.write_data[2:0] == 3'd0) ?
                                              3'd1 : r_item.write_data[2:0];
                                end
                            end
                        end
                        hhmm_pkg::CMD_TICK: begin
                            if (r_dma_busy) begin
                                // saturating accumulate
                                r_accum <= (acc_sum > 10'(hhmm_pkg::ACCUM_MAX)) ?
                                           hhmm_pkg::ACCUM_W'(hhmm_pkg::ACCUM_MAX) :
                                           acc_sum[hhmm_pkg::ACCUM_W-1:0];
                                r_n     <= '0;
                                r_state <= ST_DMA;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_RDATA: begin
                    r_out.kind           <= hhmm_pkg::KIND_READ;
                    r_out.target         <= r_dec.target;
                    r_out.target_address <= r_dec.addr;
                    r_out.data           <= rd_data;
                    r_out.data_valid     <= rd_valid;
                    r_out.oam_offset     <= 8'h00;
                    r_out.last           <= 1'b1;
                    r_done               <= 1'b1;
                    r_state              <= ST_IDLE;
                end
                ST_DMA: begin
                    // source read issued here, byte formed next cycle
                    r_dec <= dec;
                    if (r_dma_busy && (r_accum >= CPB_A) && (r_n < MAX_N)) begin
                        r_accum <= r_accum - CPB_A;
                        r_state <= ST_DMA_RD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DMA_RD: begin
                    r_out.kind           <= hhmm_pkg::KIND_DMA;
                    r_out.target         <= r_dec.target;
                    r_out.target_address <= r_dec.addr;
                    r_out.data           <= rd_data;
                    r_out.data_valid     <= rd_valid;
                    r_out.oam_offset     <= r_dma_count;
                    r_out.last           <= !dma_more;
                    r_done               <= 1'b1;
                    r_n                  <= n_plus;
                    r_dma_count          <= cnt_next[7:0];
                    if (!dma_still) begin
                        r_dma_busy <= 1'b0;
                    end
                    r_state <= dma_more ? ST_DMA : ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
